>>> sv/flvme_pkg.sv
`timescale 1ns / 1ps

package flvme_pkg;

   localparam logic [2:0] KIND_VALUE   = 3'd0;
   localparam logic [2:0] KIND_MDLEN   = 3'd1;
   localparam logic [2:0] KIND_DONE    = 3'd2;
   localparam logic [2:0] KIND_BADSIG  = 3'd3;
   localparam logic [2:0] KIND_NOTARR  = 3'd4;
   localparam logic [2:0] KIND_BADTYPE = 3'd5;
   localparam logic [2:0] KIND_TRUNC   = 3'd6;

   localparam logic [7:0] TAG_SCRIPT = 8'h12;
   localparam logic [7:0] AMF_ECMA   = 8'h08;
   localparam logic [7:0] AMF_NUMBER = 8'h00;
   localparam logic [7:0] AMF_BOOL   = 8'h01;
   localparam logic [7:0] AMF_STRING = 8'h02;
   localparam logic [7:0] AMF_OBJECT = 8'h03;

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  key_id;
      logic [63:0] payload;
      logic        last;
   } rsp_item_type;

   // results of one accepted byte, item0 first
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } parse_out_type;

endpackage

>>> sv/flv_metadata_extractor.sv
`timescale 1ns / 1ps
// FLV onMetaData extractor.
// req channel: one file byte per item. tdata is the byte, tuser flags the
// first byte of a new file (parse restarts on it), tlast flags the final byte.
// rsp channel: result items. tdata is the payload (raw double bits of a
// duration/width/height/framerate value, or the metadata region length),
// tuser carries kind and key id, tlast marks the final result of a byte.
// A byte causes zero, one or two results.
// Throughput: one byte per cycle while the queue has room; the parser updates
// its state in the cycle a byte is accepted and its results are registered
// into a 4-entry result queue, from whose head rsp is driven.
// req_tready is high while the queue has room for two results, so with the
// receiver ready, bytes flow every cycle unless a run of two-result bytes
// fills the queue; a byte that yields two results takes two output transfers.
// When the receiver stalls, results wait in the queue and input stops once
// fewer than two entries are free.
// Reset (synchronous) empties the queue and returns the parser to the file
// header; after done, an error or end of stream it drops bytes until restart.
module flv_metadata_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] restart
   input  logic        req_tlast,   // end_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] payload
   output logic [4:0]  rsp_tuser,   // [2:0] kind, [4:3] key_id
   output logic        rsp_tlast    // last
);
   import flvme_pkg::*;

   logic          accept;
   logic          space_ok;
   parse_out_type parse_out;
   rsp_item_type  head;

   assign req_tready = space_ok;
   assign accept     = req_tvalid && space_ok;

   flvme_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step_en       (accept),
      .data_byte     (req_tdata),
      .restart       (req_tuser[0]),
      .end_of_stream (req_tlast),
      .parse_out     (parse_out)
   );

   flvme_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (parse_out),
      .space_ok  (space_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tdata = head.payload;
   assign rsp_tuser = {head.key_id, head.kind};
   assign rsp_tlast = head.last;

endmodule

>>> sv/flvme_parser.sv
`timescale 1ns / 1ps

module flvme_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic [7:0]               data_byte,
   input  logic                     restart,
   input  logic                     end_of_stream,
   output flvme_pkg::parse_out_type parse_out
);
   import flvme_pkg::*;

   localparam logic [3:0] PH_FILEHDR  = 4'd0;
   localparam logic [3:0] PH_TAGHDR   = 4'd1;
   localparam logic [3:0] PH_TAGSKIP  = 4'd2;
   localparam logic [3:0] PH_PREVSZ   = 4'd3;
   localparam logic [3:0] PH_NAMESKIP = 4'd4;
   localparam logic [3:0] PH_ARRHDR   = 4'd5;
   localparam logic [3:0] PH_KEYLEN   = 4'd6;
   localparam logic [3:0] PH_KEY      = 4'd7;
   localparam logic [3:0] PH_VALUE    = 4'd8;
   localparam logic [3:0] PH_TYPE     = 4'd9;
   localparam logic [3:0] PH_STRLEN   = 4'd10;
   localparam logic [3:0] PH_VALSKIP  = 4'd11;

   localparam logic [7:0] SIG_F = "F";
   localparam logic [7:0] SIG_L = "L";
   localparam logic [7:0] SIG_V = "V";
   localparam logic [23:0] FILEHDR_LAST  = 24'd12;
   localparam logic [23:0] NAMESKIP_LAST = 24'd12;
   localparam logic [23:0] TAGHDR_LAST   = 24'd10;
   localparam logic [63:0] MDLEN_BASE    = 64'd28;

   localparam logic [7:0] KEY_LEN [4] = '{8'd8, 8'd5, 8'd6, 8'd9};
   localparam logic [7:0] KEY_TEXT [4][9] = '{
      '{"d", "u", "r", "a", "t", "i", "o", "n", 8'h00},
      '{"w", "i", "d", "t", "h", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"h", "e", "i", "g", "h", "t", 8'h00, 8'h00, 8'h00},
      '{"f", "r", "a", "m", "e", "r", "a", "t", "e"}
   };

   logic [3:0]  phase_ff, phase_in, cur_phase;
   logic [23:0] byte_count_ff, byte_count_in, cur_byte_count;
   logic [23:0] tag_length_ff, tag_length_in, cur_tag_length;
   logic [31:0] items_left_ff, items_left_in, cur_items_left;
   logic [7:0]  key_length_ff, key_length_in, cur_key_length;
   logic [7:0]  key_position_ff, key_position_in, cur_key_position;
   logic [3:0]  key_candidates_ff, key_candidates_in, cur_key_candidates;
   logic [63:0] value_shift_ff, value_shift_in, cur_value_shift;
   logic [7:0]  strlen_high_ff, strlen_high_in, cur_strlen_high;
   logic        halted_ff, halted_in, cur_halted;

   logic [23:0] tag_dec;
   logic [31:0] items_dec;
   logic [31:0] items_new;
   logic [23:0] str_len;
   logic [7:0]  pos_next;
   logic [3:0]  cand_new;
   logic [3:0]  hit;
   logic [1:0]  key_id;
   parse_out_type po;

   function automatic parse_out_type push_item(parse_out_type p, logic [2:0] kind,
                                               logic [1:0] key, logic [63:0] payload);
      rsp_item_type it;
      parse_out_type r;
      it = '{kind: kind, key_id: key, payload: payload, last: 1'b0};
      r = p;
      if (p.count == 2'd0) begin
         r.item0 = it;
         r.count = 2'd1;
      end else if (p.count == 2'd1) begin
         r.item1 = it;
         r.count = 2'd2;
      end
      return r;
   endfunction

   // restart applies the reset values before the byte is taken
   always_comb begin
      if (restart) begin
         cur_phase          = PH_FILEHDR;
         cur_byte_count     = '0;
         cur_tag_length     = '0;
         cur_items_left     = '0;
         cur_key_length     = '0;
         cur_key_position   = '0;
         cur_key_candidates = '1;
         cur_value_shift    = '0;
         cur_strlen_high    = '0;
         cur_halted         = 1'b0;
      end else begin
         cur_phase          = phase_ff;
         cur_byte_count     = byte_count_ff;
         cur_tag_length     = tag_length_ff;
         cur_items_left     = items_left_ff;
         cur_key_length     = key_length_ff;
         cur_key_position   = key_position_ff;
         cur_key_candidates = key_candidates_ff;
         cur_value_shift    = value_shift_ff;
         cur_strlen_high    = strlen_high_ff;
         cur_halted         = halted_ff;
      end
   end

   always_comb begin
      tag_dec   = cur_tag_length - 24'd1;
      items_dec = cur_items_left - 32'd1;
      items_new = {cur_items_left[23:0], data_byte};
      str_len   = {8'd0, cur_strlen_high, data_byte};
      pos_next  = cur_key_position + 8'd1;
      cand_new  = cur_key_candidates;
      for (int i = 0; i < 4; i++) begin
         if (cur_key_position >= KEY_LEN[i]) begin
            cand_new[i] = 1'b0;
         end else if (KEY_TEXT[i][cur_key_position[3:0]] != data_byte) begin
            cand_new[i] = 1'b0;
         end
      end
      hit = '0;
      for (int i = 0; i < 4; i++) begin
         if (cand_new[i] && KEY_LEN[i] == cur_key_length) begin
            hit    = '0;
            hit[i] = 1'b1;
         end
      end
      key_id = '0;
      for (int i = 0; i < 4; i++) begin
         if (cur_key_candidates[i]) begin
            key_id = 2'(i);
         end
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      byte_count_in     = byte_count_ff;
      tag_length_in     = tag_length_ff;
      items_left_in     = items_left_ff;
      key_length_in     = key_length_ff;
      key_position_in   = key_position_ff;
      key_candidates_in = key_candidates_ff;
      value_shift_in    = value_shift_ff;
      strlen_high_in    = strlen_high_ff;
      halted_in         = halted_ff;
      po                = '0;
      if (step_en) begin
         phase_in          = cur_phase;
         byte_count_in     = cur_byte_count;
         tag_length_in     = cur_tag_length;
         items_left_in     = cur_items_left;
         key_length_in     = cur_key_length;
         key_position_in   = cur_key_position;
         key_candidates_in = cur_key_candidates;
         value_shift_in    = cur_value_shift;
         strlen_high_in    = cur_strlen_high;
         halted_in         = cur_halted;
         if (!cur_halted) begin
            byte_count_in = cur_byte_count + 24'd1;
            unique case (cur_phase)
               PH_FILEHDR: begin
                  if ((cur_byte_count == 24'd0 && data_byte != SIG_F) ||
                      (cur_byte_count == 24'd1 && data_byte != SIG_L) ||
                      (cur_byte_count == 24'd2 && data_byte != SIG_V)) begin
                     po        = push_item(po, KIND_BADSIG, 2'd0, 64'd0);
                     halted_in = 1'b1;
                  end else if (cur_byte_count == FILEHDR_LAST) begin
                     phase_in      = PH_TAGHDR;
                     byte_count_in = '0;
                  end
               end
               PH_TAGHDR: begin
                  if (cur_byte_count == 24'd0) begin
                     value_shift_in = {56'd0, data_byte};
                     tag_length_in  = '0;
                  end else if (cur_byte_count <= 24'd3) begin
                     tag_length_in = {cur_tag_length[15:0], data_byte};
                  end
                  if (cur_byte_count == TAGHDR_LAST) begin
                     byte_count_in = '0;
                     if (cur_value_shift[7:0] == TAG_SCRIPT) begin
                        po = push_item(po, KIND_MDLEN, 2'd0,
                                       MDLEN_BASE + {40'd0, cur_tag_length});
                        phase_in = PH_NAMESKIP;
                     end else if (cur_tag_length == 24'd0) begin
                        phase_in = PH_PREVSZ;
                     end else begin
                        phase_in = PH_TAGSKIP;
                     end
                  end
               end
               PH_TAGSKIP: begin
                  tag_length_in = tag_dec;
                  if (tag_dec == 24'd0) begin
                     phase_in      = PH_PREVSZ;
                     byte_count_in = '0;
                  end
               end
               PH_PREVSZ: begin
                  if (cur_byte_count == 24'd3) begin
                     phase_in      = PH_TAGHDR;
                     byte_count_in = '0;
                  end
               end
               PH_NAMESKIP: begin
                  if (cur_byte_count == NAMESKIP_LAST) begin
                     phase_in      = PH_ARRHDR;
                     byte_count_in = '0;
                  end
               end
               PH_ARRHDR: begin
                  if (cur_byte_count == 24'd0) begin
                     if (data_byte != AMF_ECMA) begin
                        po        = push_item(po, KIND_NOTARR, 2'd0, 64'd0);
                        halted_in = 1'b1;
                     end
                     items_left_in = '0;
                  end else begin
                     items_left_in = items_new;
                     if (cur_byte_count == 24'd4) begin
                        if (items_new == 32'd0) begin
                           po        = push_item(po, KIND_DONE, 2'd0, 64'd0);
                           halted_in = 1'b1;
                        end else begin
                           phase_in      = PH_KEYLEN;
                           byte_count_in = '0;
                        end
                     end
                  end
               end
               PH_KEYLEN: begin
                  if (cur_byte_count == 24'd1) begin
                     key_length_in     = data_byte;
                     key_position_in   = '0;
                     key_candidates_in = '1;
                     byte_count_in     = '0;
                     phase_in          = (data_byte == 8'd0) ? PH_TYPE : PH_KEY;
                  end
               end
               PH_KEY: begin
                  key_candidates_in = cand_new;
                  key_position_in   = pos_next;
                  if (pos_next == cur_key_length) begin
                     key_candidates_in = hit;
                     byte_count_in     = '0;
                     phase_in          = (hit != 4'd0) ? PH_VALUE : PH_TYPE;
                  end
               end
               PH_VALUE: begin
                  if (cur_byte_count >= 24'd1) begin
                     value_shift_in = {cur_value_shift[55:0], data_byte};
                  end
                  if (cur_byte_count == 24'd8) begin
                     po = push_item(po, KIND_VALUE, key_id,
                                    {cur_value_shift[55:0], data_byte});
                     items_left_in = items_dec;
                     if (items_dec == 32'd0) begin
                        po        = push_item(po, KIND_DONE, 2'd0, 64'd0);
                        halted_in = 1'b1;
                     end else begin
                        phase_in      = PH_KEYLEN;
                        byte_count_in = '0;
                     end
                  end
               end
               PH_TYPE: begin
                  unique case (data_byte)
                     AMF_NUMBER: begin
                        tag_length_in = 24'd8;
                        phase_in      = PH_VALSKIP;
                        byte_count_in = '0;
                     end
                     AMF_BOOL: begin
                        tag_length_in = 24'd1;
                        phase_in      = PH_VALSKIP;
                        byte_count_in = '0;
                     end
                     AMF_STRING: begin
                        phase_in      = PH_STRLEN;
                        byte_count_in = '0;
                     end
                     AMF_OBJECT: begin
                        po        = push_item(po, KIND_DONE, 2'd0, 64'd0);
                        halted_in = 1'b1;
                     end
                     default: begin
                        po        = push_item(po, KIND_BADTYPE, 2'd0, 64'd0);
                        halted_in = 1'b1;
                     end
                  endcase
               end
               PH_STRLEN: begin
                  if (cur_byte_count == 24'd0) begin
                     strlen_high_in = data_byte;
                  end else begin
                     tag_length_in = str_len;
                     if (str_len == 24'd0) begin
                        items_left_in = items_dec;
                        if (items_dec == 32'd0) begin
                           po        = push_item(po, KIND_DONE, 2'd0, 64'd0);
                           halted_in = 1'b1;
                        end else begin
                           phase_in      = PH_KEYLEN;
                           byte_count_in = '0;
                        end
                     end else begin
                        phase_in      = PH_VALSKIP;
                        byte_count_in = '0;
                     end
                  end
               end
               PH_VALSKIP: begin
                  tag_length_in = tag_dec;
                  if (tag_dec == 24'd0) begin
                     items_left_in = items_dec;
                     if (items_dec == 32'd0) begin
                        po        = push_item(po, KIND_DONE, 2'd0, 64'd0);
                        halted_in = 1'b1;
                     end else begin
                        phase_in      = PH_KEYLEN;
                        byte_count_in = '0;
                     end
                  end
               end
               default: begin
                  halted_in = 1'b1;
               end
            endcase
            if (end_of_stream && !halted_in) begin
               po        = push_item(po, KIND_TRUNC, 2'd0, 64'd0);
               halted_in = 1'b1;
            end
            if (po.count == 2'd2) begin
               po.item1.last = 1'b1;
            end else if (po.count == 2'd1) begin
               po.item0.last = 1'b1;
            end
         end
      end
   end

   assign parse_out = po;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_FILEHDR;
         byte_count_ff     <= '0;
         tag_length_ff     <= '0;
         items_left_ff     <= '0;
         key_length_ff     <= '0;
         key_position_ff   <= '0;
         key_candidates_ff <= '1;
         value_shift_ff    <= '0;
         strlen_high_ff    <= '0;
         halted_ff         <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         byte_count_ff     <= byte_count_in;
         tag_length_ff     <= tag_length_in;
         items_left_ff     <= items_left_in;
         key_length_ff     <= key_length_in;
         key_position_ff   <= key_position_in;
         key_candidates_ff <= key_candidates_in;
         value_shift_ff    <= value_shift_in;
         strlen_high_ff    <= strlen_high_in;
         halted_ff         <= halted_in;
      end
   end

endmodule

>>> sv/flvme_rsp_fifo.sv
`timescale 1ns / 1ps

module flvme_rsp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  flvme_pkg::parse_out_type push,
   output logic                     space_ok,
   output logic                     out_valid,
   input  logic                     out_ready,
   output flvme_pkg::rsp_item_type  out_item
);
   import flvme_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic [PTR_W-1:0] wr_ptr_second;

   assign pop           = out_valid && out_ready;
   assign out_valid     = count_ff != '0;
   assign out_item      = mem_ff[rd_ptr_ff];
   assign space_ok      = count_ff <= CNT_W'(DEPTH - 2);
   assign wr_ptr_second = wr_ptr_ff + PTR_W'(1);
   assign wr_ptr_in     = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in     = rd_ptr_ff + PTR_W'(pop);
   assign count_in      = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_second] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import flvme_pkg::*;

   localparam int CYCLE_LIMIT    = 500000;
   localparam int ITEM_TARGET    = 1200;
   localparam int NO_STALL_ITEMS = 120;

   typedef enum logic [3:0] {
      P_FILEHDR, P_TAGHDR, P_TAGSKIP, P_PREVSZ, P_NAMESKIP, P_ARRHDR,
      P_KEYLEN, P_KEY, P_VALUE, P_TYPE, P_STRLEN, P_VALSKIP
   } parse_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic [0:0]  req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;

   flv_metadata_extractor dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   string key_names [4] = '{"duration", "width", "height", "framerate"};

   // parser mirror
   parse_phase_type parse_phase;
   logic [23:0]  byte_cnt;
   logic [23:0]  tag_len;
   logic [31:0]  items_left;
   logic [7:0]   key_size;
   logic [7:0]   key_pos;
   logic [3:0]   key_cand;
   logic [63:0]  value_shift;
   logic [7:0]   str_len_hi;
   logic         parser_halted;

   rsp_item_type step_results [$];
   rsp_item_type pending_results [$];
   logic [7:0]   flv_bytes [$];

   int idle_pct = 23;
   int mismatch_count = 0;
   int items_sent = 0;
   int cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL flv_metadata_extractor");
         $finish;
      end
   end

   // ---------------- prediction ----------------
   task automatic parser_reset();
      parse_phase   = P_FILEHDR;
      byte_cnt      = '0;
      tag_len       = '0;
      items_left    = '0;
      key_size      = '0;
      key_pos       = '0;
      key_cand      = 4'hF;
      value_shift   = '0;
      str_len_hi    = '0;
      parser_halted = 1'b0;
   endtask

   task automatic add_result(input logic [2:0] kind, input logic [1:0] key,
                             input logic [63:0] payload);
      rsp_item_type r;
      r.kind    = kind;
      r.key_id  = key;
      r.payload = payload;
      r.last    = 1'b0;
      step_results.push_back(r);
   endtask

   task automatic end_parse(input logic [2:0] kind);
      add_result(kind, 2'd0, 64'd0);
      parser_halted = 1'b1;
   endtask

   task automatic next_phase(input parse_phase_type p);
      parse_phase = p;
      byte_cnt    = '0;
   endtask

   task automatic item_finished();
      items_left = items_left - 32'd1;
      if (items_left == 0) end_parse(KIND_DONE);
      else next_phase(P_KEYLEN);
   endtask

   task automatic flv_predict(input logic [7:0] b, input logic rs, input logic eos);
      logic [23:0] c;
      logic [3:0]  hit;
      logic [1:0]  id;
      int          i;
      step_results.delete();
      if (rs) parser_reset();
      if (parser_halted) return;
      c = byte_cnt;
      byte_cnt = byte_cnt + 24'd1;
      case (parse_phase)
         P_FILEHDR: begin
            if ((c == 0 && b != "F") || (c == 1 && b != "L") || (c == 2 && b != "V"))
               end_parse(KIND_BADSIG);
            else if (c == 12)
               next_phase(P_TAGHDR);
         end
         P_TAGHDR: begin
            if (c == 0) begin
               value_shift = {56'd0, b};
               tag_len = '0;
            end else if (c <= 3) begin
               tag_len = {tag_len[15:0], b};
            end
            if (c == 10) begin
               if (value_shift[7:0] == TAG_SCRIPT) begin
                  add_result(KIND_MDLEN, 2'd0, 64'd28 + {40'd0, tag_len});
                  next_phase(P_NAMESKIP);
               end else begin
                  next_phase(tag_len == 0 ? P_PREVSZ : P_TAGSKIP);
               end
            end
         end
         P_TAGSKIP: begin
            tag_len = tag_len - 24'd1;
            if (tag_len == 0) next_phase(P_PREVSZ);
         end
         P_PREVSZ: begin
            if (c == 3) next_phase(P_TAGHDR);
         end
         P_NAMESKIP: begin
            if (c == 12) next_phase(P_ARRHDR);
         end
         P_ARRHDR: begin
            if (c == 0) begin
               if (b != AMF_ECMA) end_parse(KIND_NOTARR);
               items_left = '0;
            end else begin
               items_left = {items_left[23:0], b};
               if (c == 4) begin
                  if (items_left == 0) end_parse(KIND_DONE);
                  else next_phase(P_KEYLEN);
               end
            end
         end
         P_KEYLEN: begin
            if (c == 1) begin
               key_size = b;
               key_pos  = '0;
               key_cand = 4'hF;
               next_phase(b == 0 ? P_TYPE : P_KEY);
            end
         end
         P_KEY: begin
            for (i = 0; i < 4; i++)
               if (key_pos >= key_names[i].len() || key_names[i][key_pos] != b)
                  key_cand[i] = 1'b0;
            key_pos = key_pos + 8'd1;
            if (key_pos == key_size) begin
               hit = '0;
               for (i = 0; i < 4; i++)
                  if (key_cand[i] && key_names[i].len() == key_size) hit = 4'b1 << i;
               key_cand = hit;
               next_phase(hit != 0 ? P_VALUE : P_TYPE);
            end
         end
         P_VALUE: begin
            if (c >= 1) value_shift = {value_shift[55:0], b};
            if (c == 8) begin
               id = '0;
               for (i = 0; i < 4; i++)
                  if (key_cand[i]) id = 2'(i);
               add_result(KIND_VALUE, id, value_shift);
               item_finished();
            end
         end
         P_TYPE: begin
            case (b)
               AMF_NUMBER: begin
                  tag_len = 24'd8;
                  next_phase(P_VALSKIP);
               end
               AMF_BOOL: begin
                  tag_len = 24'd1;
                  next_phase(P_VALSKIP);
               end
               AMF_STRING: next_phase(P_STRLEN);
               AMF_OBJECT: end_parse(KIND_DONE);
               default: end_parse(KIND_BADTYPE);
            endcase
         end
         P_STRLEN: begin
            if (c == 0) begin
               str_len_hi = b;
            end else begin
               tag_len = {8'd0, str_len_hi, b};
               if (tag_len == 0) item_finished();
               else next_phase(P_VALSKIP);
            end
         end
         P_VALSKIP: begin
            tag_len = tag_len - 24'd1;
            if (tag_len == 0) item_finished();
         end
         default: parser_halted = 1'b1;
      endcase
      if (eos && !parser_halted) end_parse(KIND_TRUNC);
      for (i = 0; i < step_results.size(); i++) begin
         step_results[i].last = (i == step_results.size() - 1);
         pending_results.push_back(step_results[i]);
      end
   endtask

   // ---------------- driving ----------------
   task automatic send_byte(input logic [7:0] b, input logic rs, input logic eos);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= rs;
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      flv_predict(b, rs, eos);
   endtask

   task automatic send_flv(input logic rs, input logic eos);
      int i;
      for (i = 0; i < flv_bytes.size(); i++)
         send_byte(flv_bytes[i], rs && i == 0, eos && i == flv_bytes.size() - 1);
      flv_bytes.delete();
   endtask

   // ---------------- file building ----------------
   task automatic put(input logic [7:0] b);
      flv_bytes.push_back(b);
   endtask

   task automatic put_be(input logic [63:0] v, input int n);
      int i;
      for (i = n - 1; i >= 0; i--) put(v[8 * i +: 8]);
   endtask

   task automatic put_junk(input int n);
      repeat (n) put(8'($urandom));
   endtask

   // bad_pos 0..2 corrupts that signature byte, 3 keeps it intact
   task automatic put_file_header(input int bad_pos);
      logic [7:0] sig [3];
      sig = '{"F", "L", "V"};
      if (bad_pos < 3) sig[bad_pos] = sig[bad_pos] ^ 8'($urandom_range(1, 255));
      put(sig[0]);
      put(sig[1]);
      put(sig[2]);
      put_junk(10);
   endtask

   task automatic put_other_tag(input logic [7:0] tag_kind, input int len);
      put(tag_kind == TAG_SCRIPT ? 8'h09 : tag_kind);
      put_be(64'(len), 3);
      put_junk(7);
      put_junk(len);
      put_junk(4);
   endtask

   task automatic put_script_head(input logic [23:0] len, input logic [7:0] marker,
                                  input logic [31:0] count);
      put(TAG_SCRIPT);
      put_be({40'd0, len}, 3);
      put_junk(7);
      put_junk(13);
      put(marker);
      put_be({32'd0, count}, 4);
   endtask

   task automatic put_key(input string s, input logic [7:0] len_hi);
      int i;
      put(len_hi);
      put(8'(s.len()));
      for (i = 0; i < s.len(); i++) put(s[i]);
   endtask

   task automatic put_random_key(input int n);
      put($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h00);
      put(8'(n));
      repeat (n) put(8'($urandom_range(8'h61, 8'h7a)));
   endtask

   task automatic put_double_item(input string s, input logic [63:0] v);
      put_key(s, $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h00);
      put(8'($urandom));
      put_be(v, 8);
   endtask

   task automatic put_skip_value(input logic [7:0] amf, input logic [15:0] slen);
      put(amf);
      case (amf)
         AMF_NUMBER: put_junk(8);
         AMF_BOOL: put_junk(1);
         default: begin
            put_be({48'd0, slen}, 2);
            put_junk(int'(slen));
         end
      endcase
   endtask

   task automatic put_random_skip_value();
      logic [7:0]  amf;
      logic [15:0] slen;
      amf  = 8'($urandom_range(0, 2));
      slen = $urandom_range(0, 19) == 0 ? 16'($urandom_range(256, 259))
                                        : 16'($urandom_range(0, 8));
      put_skip_value(amf, slen);
   endtask

   function automatic logic [63:0] rand_double();
      case ($urandom_range(0, 7))
         0: rand_double = '0;
         1: rand_double = '1;
         default: rand_double = {$urandom, $urandom};
      endcase
   endfunction

   function automatic string near_miss(input string s);
      string t;
      t = s;
      case ($urandom_range(0, 2))
         0: t = s.substr(0, s.len() - 2);
         1: t = {s, "s"};
         default: t[$urandom_range(0, s.len() - 1)] = "x";
      endcase
      return t;
   endfunction

   task automatic put_random_item();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel < 4) begin
         put_double_item(key_names[sel], rand_double());
      end else if (sel < 6) begin
         put_random_key($urandom_range(0, 10));
         put_random_skip_value();
      end else begin
         put_key(near_miss(key_names[$urandom_range(0, 3)]), 8'h00);
         put_random_skip_value();
      end
   endtask

   task automatic put_random_front();
      repeat ($urandom_range(0, 2)) put_other_tag(8'($urandom), $urandom_range(0, 12));
   endtask

   // ---------------- checking ----------------
   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycles, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected item tuser=%h tdata=%h tlast=%b",
                                         rsp_tuser, rsp_tdata, rsp_tlast));
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser[2:0] !== want.kind || rsp_tuser[4:3] !== want.key_id ||
                   rsp_tdata !== want.payload || rsp_tlast !== want.last)
                  report_mismatch($sformatf(
                     "kind %0d/%0d key %0d/%0d payload %h/%h last %b/%b (got/want)",
                     rsp_tuser[2:0], want.kind, rsp_tuser[4:3], want.key_id,
                     rsp_tdata, want.payload, rsp_tlast, want.last));
            end
         end
         rsp_tready <= $urandom_range(0, 99) >= idle_pct;
      end
   end

   // ---------------- tests ----------------
   task automatic test_signature();
      // first file goes in straight after reset, without restart
      put_file_header(0);
      put_junk(4);
      send_flv(1'b0, 1'b0);
      put_file_header(1);
      send_flv(1'b1, 1'b0);
      put_file_header(2);
      put_junk(3);
      send_flv(1'b1, 1'b1);
      // lone bytes carrying both restart and end of stream
      send_byte("F", 1'b1, 1'b1);
      send_byte("Z", 1'b1, 1'b1);
   endtask

   task automatic test_metadata_values();
      put_file_header(3);
      put_other_tag(8'h08, 0);
      put_other_tag(8'h09, 5);
      put_script_head(24'hFFFFFF, AMF_ECMA, 32'd10);
      put_double_item("duration", 64'h0);
      put_double_item("width", 64'hFFFF_FFFF_FFFF_FFFF);
      put_double_item("height", {$urandom, $urandom});
      put_double_item("framerate", 64'h4039_0000_0000_0000);
      put_key("abc", 8'h00);
      put_skip_value(AMF_NUMBER, 16'd0);
      put_key("", 8'h00);
      put_skip_value(AMF_BOOL, 16'd0);
      put_key("widt", 8'h00);
      put_skip_value(AMF_STRING, 16'd0);
      put_key("widths", 8'hFF);
      put_skip_value(AMF_STRING, 16'd3);
      put_key("hoight", 8'h00);
      put_skip_value(AMF_NUMBER, 16'd0);
      put_key("videocodecid", 8'h00);
      put_skip_value(AMF_STRING, 16'h0100);
      put_junk(3);
      send_flv(1'b1, 1'b0);
      // value and end of stream on one byte
      put_file_header(3);
      put_script_head(24'h000000, AMF_ECMA, 32'd2);
      put_double_item("framerate", {$urandom, $urandom});
      send_flv(1'b1, 1'b1);
      // value and done on one byte, end of stream there too
      put_file_header(3);
      put_script_head(24'h123456, AMF_ECMA, 32'd1);
      put_double_item("duration", {$urandom, $urandom});
      send_flv(1'b1, 1'b1);
   endtask

   task automatic test_parse_errors();
      put_file_header(3);
      put_script_head(24'd40, 8'h0A, 32'd1);
      send_flv(1'b1, 1'b0);
      put_file_header(3);
      put_script_head(24'd40, AMF_ECMA, 32'd3);
      put_key("foo", 8'h00);
      put(8'h04);
      put_junk(2);
      send_flv(1'b1, 1'b0);
      put_file_header(3);
      put_script_head(24'd40, AMF_ECMA, 32'd3);
      put_key("", 8'h00);
      put(8'hFF);
      send_flv(1'b1, 1'b0);
      put_file_header(3);
      put_script_head(24'd40, AMF_ECMA, 32'hFFFF_FFFF);
      put_key("x", 8'h00);
      put(AMF_OBJECT);
      put_junk(2);
      send_flv(1'b1, 1'b0);
      put_file_header(3);
      put_script_head(24'd5, AMF_ECMA, 32'd0);
      put_junk(2);
      send_flv(1'b1, 1'b0);
      // end of stream in the middle of a skipped tag
      put_file_header(3);
      put_other_tag(8'h09, 6);
      repeat (6) void'(flv_bytes.pop_back());
      send_flv(1'b1, 1'b1);
      // restart arrives in the middle of a file
      put_file_header(3);
      put_script_head(24'd9, AMF_ECMA, 32'd2);
      put_key("dur", 8'h00);
      send_flv(1'b1, 1'b0);
      put_file_header(3);
      put_script_head(24'd9, AMF_ECMA, 32'd1);
      put_double_item("height", 64'h4080_0000_0000_0000);
      send_flv(1'b1, 1'b0);
   endtask

   task automatic send_random_file();
      int          n_items;
      int          sel;
      logic [31:0] count;
      logic        eos;
      n_items = $urandom_range(1, 6);
      sel = $urandom_range(0, 9);
      if (sel == 0) count = $urandom_range(1, n_items);
      else if (sel == 1) count = n_items + $urandom_range(1, 3);
      else if (sel == 2) count = $urandom | 32'h0100_0000;
      else count = n_items;
      put_file_header(3);
      put_random_front();
      put_script_head($urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 400)),
                      AMF_ECMA, count);
      repeat (n_items) put_random_item();
      if (count > n_items && $urandom_range(0, 1) == 0) begin
         put_random_key($urandom_range(0, 4));
         put(AMF_OBJECT);
      end
      put_junk($urandom_range(0, 3));
      sel = $urandom_range(0, 9);
      eos = sel < 5;
      if (sel < 2)
         while (flv_bytes.size() > $urandom_range(1, flv_bytes.size()))
            void'(flv_bytes.pop_back());
      send_flv(1'b1, eos);
   endtask

   task automatic send_broken_file();
      case ($urandom_range(0, 2))
         0: begin
            put_file_header($urandom_range(0, 2));
            put_junk(5);
         end
         1: begin
            put_file_header(3);
            put_random_front();
            put_script_head(24'($urandom), AMF_ECMA ^ 8'($urandom_range(1, 255)), $urandom);
         end
         default: begin
            put_file_header(3);
            put_script_head(24'($urandom_range(0, 99)), AMF_ECMA, 32'd3);
            if ($urandom_range(0, 1) == 0) put_random_item();
            put_random_key($urandom_range(0, 6));
            put(8'($urandom_range(4, 255)));
         end
      endcase
      put_junk($urandom_range(0, 3));
      send_flv(1'b1, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 20))
         send_byte(8'($urandom), $urandom_range(0, 19) == 0, $urandom_range(0, 9) == 0);
   endtask

   task automatic test_no_stall();
      int start_items;
      start_items = items_sent;
      idle_pct = 0;
      while (items_sent - start_items < NO_STALL_ITEMS) send_random_file();
      idle_pct = 23;
   endtask

   task automatic test_random_files();
      int sel;
      while (items_sent < ITEM_TARGET) begin
         sel = $urandom_range(0, 99);
         if (sel < 75) send_random_file();
         else if (sel < 90) send_broken_file();
         else send_noise();
      end
   endtask

   initial begin
      parser_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_signature();
      test_metadata_values();
      test_parse_errors();
      test_no_stall();
      test_random_files();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) $display("PASS flv_metadata_extractor");
      else $display("FAIL flv_metadata_extractor");
      $finish;
   end

endmodule
